FILE: rtl/lfsa_pkg.sv
// shared types, constants and helpers of the lowest free slot allocator
package lfsa_pkg;

   localparam int MAX_SEATS_DEF = 1024;
   localparam int CNT_W = 11;
   localparam int POS_W = 12;
   localparam int WORD_W = 32;
   localparam int BIT_W = $clog2(WORD_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int SEAT_LIMIT = 2047;

   localparam logic [CNT_W-1:0] SEATS_RESET = 11'd1024;

   localparam logic ACTION_RESERVE = 1'b0;
   localparam logic ACTION_RELEASE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [1:0] {
      KIND_RESERVE,
      KIND_RELEASE,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [CNT_W-1:0] seat;
   } cmd_type;

   function automatic int seat_cap(input int max_seats);
      return (max_seats < SEAT_LIMIT) ? max_seats : SEAT_LIMIT;
   endfunction

   // index of the lowest set bit, zero when none
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] onehot;
      logic [BIT_W-1:0]  idx;
      onehot = x & (~x + WORD_W'(1));
      idx = '0;
      for (int j = 0; j < WORD_W; j++) begin
         idx = idx | (onehot[j] ? BIT_W'(j) : '0);
      end
      return idx;
   endfunction

endpackage

FILE: rtl/lowest_free_slot_allocator.sv
// top level: slot count register, front end, command queue and bitmap engine
// answers: a release or reserve word answers once its bitmap row has been read, and a
// reserve search also reads each further row it crosses; rejected words and reserves with
// the pointer past the slot count answer straight from idle; the engine finishes one word
// before it pops the next, and after a grant a reserve reads rows one by one for the next free slot
// reset: busy stays high while the ceil(min(MAX_SEATS,2047)/32) bitmap rows (32 by default)
// are cleared; the result strobe cannot be stalled
module lowest_free_slot_allocator #(
   parameter int MAX_SEATS = lfsa_pkg::MAX_SEATS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_action,
   input  logic [lfsa_pkg::CNT_W-1:0] req_seat,
   output logic                       rsp_valid,
   output logic [lfsa_pkg::CNT_W-1:0] rsp_granted_seat,
   output logic [1:0]                 rsp_status,
   input  logic                       csr_wr_en,
   input  logic [lfsa_pkg::CNT_W-1:0] csr_wr_data
);

   localparam int CNT_W = lfsa_pkg::CNT_W;
   localparam logic [CNT_W-1:0] CAP = CNT_W'(lfsa_pkg::seat_cap(MAX_SEATS));

   logic [CNT_W-1:0]  seats_ff;
   logic [CNT_W-1:0]  slot_count;
   logic              push;
   lfsa_pkg::cmd_type push_cmd;
   logic              pop;
   logic              q_valid;
   lfsa_pkg::cmd_type q_cmd;
   logic              q_full;
   logic              clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         seats_ff <= lfsa_pkg::SEATS_RESET;
      end else if (csr_wr_en) begin
         seats_ff <= csr_wr_data;
      end
   end

   assign slot_count = (seats_ff > CAP) ? CAP : seats_ff;

   lfsa_front u_front (
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_seat   (req_seat),
      .slot_count (slot_count),
      .q_full     (q_full),
      .clearing   (clearing),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   lfsa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_full   (q_full)
   );

   lfsa_back #(
      .MAX_SEATS (MAX_SEATS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .slot_count       (slot_count),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_granted_seat (rsp_granted_seat),
      .rsp_status       (rsp_status)
   );

endmodule

FILE: rtl/lfsa_front.sv
// front end: takes request words and classifies them for the command queue
module lfsa_front (
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_action,
   input  logic [lfsa_pkg::CNT_W-1:0]     req_seat,
   input  logic [lfsa_pkg::CNT_W-1:0]     slot_count,
   input  logic                           q_full,
   input  logic                           clearing,
   output logic                           push,
   output lfsa_pkg::cmd_type              push_cmd
);

   logic seat_ok;

   assign busy = q_full || clearing;
   assign push = start && !busy;
   assign seat_ok = (req_seat != '0) && (req_seat <= slot_count);

   always_comb begin
      push_cmd.seat = req_seat;
      if (req_action == lfsa_pkg::ACTION_RESERVE) begin
         push_cmd.kind = lfsa_pkg::KIND_RESERVE;
      end else if (seat_ok) begin
         push_cmd.kind = lfsa_pkg::KIND_RELEASE;
      end else begin
         push_cmd.kind = lfsa_pkg::KIND_BAD;
      end
   end

endmodule

FILE: rtl/lfsa_queue.sv
// short command queue between the front end and the bitmap engine
module lfsa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lfsa_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              q_valid,
   output lfsa_pkg::cmd_type q_cmd,
   output logic              q_full
);

   localparam int DEPTH = lfsa_pkg::QUEUE_DEPTH;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lfsa_pkg::cmd_type entry_ff [DEPTH];
   logic [IDX_W-1:0]  wr_idx_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push;
   logic              do_pop;

   assign q_valid = (count_ff != '0);
   assign q_full = (count_ff == CNT_W'(DEPTH));
   assign q_cmd = entry_ff[rd_idx_ff];
   assign do_push = push && !q_full;
   assign do_pop = pop && q_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_idx_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_idx_ff <= (wr_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
         end
         if (do_pop) begin
            rd_idx_ff <= (rd_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/lfsa_back.sv
// bitmap engine: occupancy rows in memory, row-wide free search and pointer upkeep
module lfsa_back #(
   parameter int MAX_SEATS = lfsa_pkg::MAX_SEATS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lfsa_pkg::CNT_W-1:0] slot_count,
   input  logic                       q_valid,
   input  lfsa_pkg::cmd_type          q_cmd,
   output logic                       q_pop,
   output logic                       clearing,
   output logic                       rsp_valid,
   output logic [lfsa_pkg::CNT_W-1:0] rsp_granted_seat,
   output logic [1:0]                 rsp_status
);

   localparam int CNT_W = lfsa_pkg::CNT_W;
   localparam int POS_W = lfsa_pkg::POS_W;
   localparam int WORD_W = lfsa_pkg::WORD_W;
   localparam int BIT_W = lfsa_pkg::BIT_W;
   localparam int CAP = lfsa_pkg::seat_cap(MAX_SEATS);
   localparam int ROWS = (CAP + WORD_W - 1) / WORD_W;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND,
      ST_NEXT,
      ST_REL
   } state_type;

   logic [WORD_W-1:0] mem [ROWS];
   logic [WORD_W-1:0] rd_data_ff;

   state_type         state_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [POS_W-1:0]  ptr_ff;
   lfsa_pkg::cmd_type cmd_ff;
   logic              rsp_valid_ff;
   logic [CNT_W-1:0]  rsp_seat_ff;
   logic [1:0]        rsp_status_ff;

   logic [POS_W-1:0]  count_pos;
   logic [POS_W-1:0]  last_idx;
   logic [ROW_W-1:0]  last_row;
   logic [POS_W-1:0]  lo_idx;
   logic [ROW_W-1:0]  lo_row;
   logic [POS_W-1:0]  head_rel_idx;
   logic [POS_W-1:0]  rel_idx;
   logic [WORD_W-1:0] mask_lo;
   logic [WORD_W-1:0] mask_hi;
   logic [WORD_W-1:0] free_bits;
   logic [WORD_W-1:0] free_next;
   logic [BIT_W-1:0]  pick;
   logic [BIT_W-1:0]  pick_next;
   logic [POS_W-1:0]  pick_pos;
   logic [POS_W-1:0]  pick_next_pos;
   logic              at_last_row;
   logic [ROW_W-1:0]  mem_raddr;
   logic              mem_we;
   logic [ROW_W-1:0]  mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   assign count_pos = {1'b0, slot_count};
   assign last_idx = count_pos - 1'b1;
   assign last_row = last_idx[ROW_W+BIT_W-1:BIT_W];
   assign lo_idx = ptr_ff - 1'b1;
   assign lo_row = lo_idx[ROW_W+BIT_W-1:BIT_W];
   assign head_rel_idx = {1'b0, q_cmd.seat} - 1'b1;
   assign rel_idx = {1'b0, cmd_ff.seat} - 1'b1;
   assign at_last_row = (row_ff == last_row);

   // candidate free bits of the current row inside [pointer, slot count]
   assign mask_lo = (row_ff == lo_row) ? ({WORD_W{1'b1}} << lo_idx[BIT_W-1:0])
                                       : {WORD_W{1'b1}};
   assign mask_hi = at_last_row
                    ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_idx[BIT_W-1:0]))
                    : {WORD_W{1'b1}};
   assign free_bits = ~rd_data_ff & mask_lo & mask_hi;
   assign free_next = free_bits & (free_bits - 1'b1);
   assign pick = lfsa_pkg::lowest_set(free_bits);
   assign pick_next = lfsa_pkg::lowest_set(free_next);
   assign pick_pos = POS_W'({row_ff, pick}) + 1'b1;
   assign pick_next_pos = POS_W'({row_ff, pick_next}) + 1'b1;

   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign clearing = (state_ff == ST_CLEAR);

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            if (q_cmd.kind == lfsa_pkg::KIND_RESERVE) begin
               mem_raddr = lo_row;
            end else begin
               mem_raddr = head_rel_idx[ROW_W+BIT_W-1:BIT_W];
            end
         end
         ST_FIND, ST_NEXT: mem_raddr = row_ff + 1'b1;
         default: mem_raddr = row_ff;
      endcase
   end

   always_comb begin
      mem_waddr = row_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wdata = '0;
         end
         ST_FIND: begin
            mem_we = (free_bits != '0);
            mem_wdata = rd_data_ff | (WORD_W'(1) << pick);
         end
         ST_REL: begin
            mem_we = 1'b1;
            mem_wdata = rd_data_ff & ~(WORD_W'(1) << rel_idx[BIT_W-1:0]);
         end
         default: begin
            mem_we = 1'b0;
            mem_wdata = rd_data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         row_ff <= '0;
         ptr_ff <= POS_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               if (row_ff == ROW_W'(ROWS - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  row_ff <= row_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (q_valid) begin
                  cmd_ff <= q_cmd;
                  case (q_cmd.kind)
                     lfsa_pkg::KIND_RESERVE: begin
                        if (ptr_ff > count_pos) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_seat_ff <= '0;
                           rsp_status_ff <= lfsa_pkg::STATUS_FULL;
                        end else begin
                           row_ff <= lo_row;
                           state_ff <= ST_FIND;
                        end
                     end
                     lfsa_pkg::KIND_RELEASE: begin
                        row_ff <= head_rel_idx[ROW_W+BIT_W-1:BIT_W];
                        state_ff <= ST_REL;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_seat_ff <= '0;
                        rsp_status_ff <= lfsa_pkg::STATUS_RANGE;
                     end
                  endcase
               end
            end
            ST_FIND: begin
               if (free_bits != '0) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_seat_ff <= pick_pos[CNT_W-1:0];
                  rsp_status_ff <= lfsa_pkg::STATUS_OK;
                  if (free_next != '0) begin
                     ptr_ff <= pick_next_pos;
                     state_ff <= ST_IDLE;
                  end else if (at_last_row) begin
                     ptr_ff <= count_pos + 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                     state_ff <= ST_NEXT;
                  end
               end else if (at_last_row) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_seat_ff <= '0;
                  rsp_status_ff <= lfsa_pkg::STATUS_FULL;
                  state_ff <= ST_IDLE;
               end else begin
                  row_ff <= row_ff + 1'b1;
               end
            end
            ST_NEXT: begin
               if (free_bits != '0) begin
                  ptr_ff <= pick_pos;
                  state_ff <= ST_IDLE;
               end else if (at_last_row) begin
                  ptr_ff <= count_pos + 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  row_ff <= row_ff + 1'b1;
               end
            end
            ST_REL: begin
               rsp_valid_ff <= 1'b1;
               rsp_seat_ff <= '0;
               rsp_status_ff <= lfsa_pkg::STATUS_OK;
               if ({1'b0, cmd_ff.seat} < ptr_ff) begin
                  ptr_ff <= {1'b0, cmd_ff.seat};
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_granted_seat = rsp_seat_ff;
   assign rsp_status = rsp_status_ff;

   a_quiet_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response during bitmap clear");

   a_ptr_nonzero: assert property (@(posedge clock) disable iff (reset)
      ptr_ff != '0)
      else $error("free pointer at zero");

   a_reject_no_seat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != lfsa_pkg::STATUS_OK)) |-> (rsp_seat_ff == '0))
      else $error("rejected word carries a seat");

   a_grant_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_seat_ff != '0)) |-> (rsp_seat_ff <= slot_count))
      else $error("granted seat beyond slot count");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_CLEAR) || (state_ff == ST_FIND) || (state_ff == ST_REL)))
      else $error("bitmap write outside a writing state");

endmodule
